/* hdl/p2rc_pkg.sv */
// p2rc_pkg: shared types, codes and helpers of the pose-to-corners pipeline.
// No dependencies.
`timescale 1ns / 1ps
package p2rc_pkg;

  localparam int DIV_STAGES = 32;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  // Register select bit (paddr[2]).
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [30:0] SIZE_RESET = 31'd65536;

  // Per-pose terms: rotation numerators already scaled by the half sizes.
  typedef struct packed {
    logic signed [63:0] a_x;
    logic signed [63:0] a_y;
    logic signed [63:0] a_z;
    logic signed [63:0] b_x;
    logic signed [63:0] b_y;
    logic signed [63:0] b_z;
    logic [32:0]        norm;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [29:0]        half_w;
    logic [29:0]        half_h;
  } item_t;

  // Per-corner sideband that travels beside the divider lanes.
  typedef struct packed {
    logic [1:0]         idx;
    logic               zero;
    logic [2:0]         neg;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [30:0] dx;
    logic signed [30:0] dy;
  } beat_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end
    return r;
  endfunction

endpackage

/* hdl/p2rc_terms.sv */
// p2rc_terms: three-stage front end: quaternion products, rotation
// numerators and norm, then scaling by the half sizes. Uses p2rc_pkg.
`timescale 1ns / 1ps
module p2rc_terms (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [15:0]  qw,
  input  logic signed [15:0]  qx,
  input  logic signed [15:0]  qy,
  input  logic signed [15:0]  qz,
  input  logic [29:0]         half_w,
  input  logic [29:0]         half_h,
  output logic                item_valid,
  input  logic                item_ready,
  output p2rc_pkg::item_t     item
);
  import p2rc_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  logic signed [31:0] p1x_r, p1y_r, p1z_r, p2x_r, p2y_r, p2z_r;
  logic [29:0] hw1_r, hh1_r, hw2_r, hh2_r;
  logic [32:0] norm2_r;
  logic signed [33:0] n00_r, n01_r, n10_r, n11_r, n20_r, n21_r;
  item_t item_r;

  assign rdy3 = !v3_r || item_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign item_valid = v3_r;
  assign item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      ww_r  <= qw * qw;
      xx_r  <= qx * qx;
      yy_r  <= qy * qy;
      zz_r  <= qz * qz;
      xy_r  <= qx * qy;
      wz_r  <= qw * qz;
      xz_r  <= qx * qz;
      wy_r  <= qw * qy;
      yz_r  <= qy * qz;
      wx_r  <= qw * qx;
      p1x_r <= pos_x;
      p1y_r <= pos_y;
      p1z_r <= pos_z;
      hw1_r <= half_w;
      hh1_r <= half_h;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      norm2_r <= 33'(ww_r) + 33'(xx_r) + 33'(yy_r) + 33'(zz_r);
      n00_r   <= 34'(ww_r) + 34'(xx_r) - 34'(yy_r) - 34'(zz_r);
      n01_r   <= (34'(xy_r) - 34'(wz_r)) <<< 1;
      n10_r   <= (34'(xy_r) + 34'(wz_r)) <<< 1;
      n11_r   <= 34'(ww_r) - 34'(xx_r) + 34'(yy_r) - 34'(zz_r);
      n20_r   <= (34'(xz_r) - 34'(wy_r)) <<< 1;
      n21_r   <= (34'(yz_r) + 34'(wx_r)) <<< 1;
      p2x_r   <= p1x_r;
      p2y_r   <= p1y_r;
      p2z_r   <= p1z_r;
      hw2_r   <= hw1_r;
      hh2_r   <= hh1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      item_r.a_x    <= n00_r * $signed({1'b0, hw2_r});
      item_r.b_x    <= n01_r * $signed({1'b0, hh2_r});
      item_r.a_y    <= n10_r * $signed({1'b0, hw2_r});
      item_r.b_y    <= n11_r * $signed({1'b0, hh2_r});
      item_r.a_z    <= n20_r * $signed({1'b0, hw2_r});
      item_r.b_z    <= n21_r * $signed({1'b0, hh2_r});
      item_r.norm   <= norm2_r;
      item_r.pos_x  <= p2x_r;
      item_r.pos_y  <= p2y_r;
      item_r.pos_z  <= p2z_r;
      item_r.half_w <= hw2_r;
      item_r.half_h <= hh2_r;
    end
  end

endmodule

/* hdl/p2rc_corner.sv */
// p2rc_corner: holds one pose and issues its four corners, one per cycle
// while adv is high, then folds sign and rounding bias into the dividends. Uses p2rc_pkg.
`timescale 1ns / 1ps
module p2rc_corner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                item_valid,
  output logic                item_ready,
  input  p2rc_pkg::item_t     item,
  output logic                beat_valid,
  output p2rc_pkg::beat_t     beat,
  output logic [32:0]         norm,
  output logic [2:0][62:0]    dvd
);
  import p2rc_pkg::*;

  item_t item_r;
  logic iv_r;
  logic [1:0] cnt_r;

  logic ev_r, mv_r;
  logic signed [63:0] s_r [3];
  logic signed [63:0] s_nxt [3];
  beat_t eb_r, mb_r;
  logic [32:0] en_r, mn_r;
  logic [2:0][62:0] d_r;

  logic pos_a, pos_b;
  logic signed [63:0] sa [3];
  logic signed [63:0] sb [3];
  logic signed [63:0] half_n;

  assign item_ready = !iv_r || (adv && cnt_r == CORNER_LAST);
  assign beat_valid = mv_r;
  assign beat = mb_r;
  assign norm = mn_r;
  assign dvd = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else if (item_valid && item_ready) begin
      iv_r  <= 1'b1;
      cnt_r <= 2'd0;
    end else if (adv && iv_r) begin
      cnt_r <= cnt_r + 2'd1;
      if (cnt_r == CORNER_LAST) iv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) item_r <= item;
  end

  always_comb begin
    pos_a = (cnt_r == 2'd0) || (cnt_r == CORNER_LAST);
    pos_b = (cnt_r == 2'd0) || (cnt_r == 2'd1);
    sa[0] = pos_a ? item_r.a_x : -item_r.a_x;
    sa[1] = pos_a ? item_r.a_y : -item_r.a_y;
    sa[2] = pos_a ? item_r.a_z : -item_r.a_z;
    sb[0] = pos_b ? item_r.b_x : -item_r.b_x;
    sb[1] = pos_b ? item_r.b_y : -item_r.b_y;
    sb[2] = pos_b ? item_r.b_z : -item_r.b_z;
    for (int i = 0; i < 3; i++) begin
      s_nxt[i] = sa[i] + sb[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= 1'b0;
      mv_r <= 1'b0;
    end else if (adv) begin
      ev_r <= iv_r;
      mv_r <= ev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && iv_r) begin
      for (int i = 0; i < 3; i++) begin
        s_r[i]     <= s_nxt[i];
        eb_r.neg[i] <= s_nxt[i][63];
      end
      en_r       <= item_r.norm;
      eb_r.idx   <= cnt_r;
      eb_r.zero  <= (item_r.norm == 33'd0);
      eb_r.pos_x <= item_r.pos_x;
      eb_r.pos_y <= item_r.pos_y;
      eb_r.pos_z <= item_r.pos_z;
      eb_r.dx    <= pos_a ? $signed({1'b0, item_r.half_w}) : -$signed({1'b0, item_r.half_w});
      eb_r.dy    <= pos_b ? $signed({1'b0, item_r.half_h}) : -$signed({1'b0, item_r.half_h});
    end
  end

  assign half_n = $signed({32'd0, en_r[32:1]});

  always_ff @(posedge clk) begin
    if (adv && ev_r) begin
      mb_r <= eb_r;
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= s_r[i][63] ? 63'(half_n - s_r[i]) : 63'(s_r[i] + half_n);
      end
      mn_r <= en_r;
    end
  end

endmodule

/* hdl/p2rc_div.sv */
// p2rc_div: three-lane restoring divider, one quotient bit per stage,
// with the corner sideband carried alongside. Uses p2rc_pkg.
`timescale 1ns / 1ps
module p2rc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  p2rc_pkg::beat_t     in_beat,
  input  logic [32:0]         in_norm,
  input  logic [2:0][62:0]    in_dvd,
  output logic                out_valid,
  output p2rc_pkg::beat_t     out_beat,
  output logic [2:0][31:0]    quot
);
  import p2rc_pkg::*;

  logic        v_r    [DIV_STAGES];
  beat_t       b_r    [DIV_STAGES];
  logic [32:0] n_r    [DIV_STAGES];
  logic [32:0] rem_r  [3][DIV_STAGES];
  logic [31:0] low_r  [3][DIV_STAGES];

  logic        v_in   [DIV_STAGES];
  beat_t       b_in   [DIV_STAGES];
  logic [32:0] n_in   [DIV_STAGES];
  logic [32:0] rem_in [3][DIV_STAGES];
  logic [31:0] low_in [3][DIV_STAGES];
  logic [32:0] rem_nxt [3][DIV_STAGES];
  logic [31:0] low_nxt [3][DIV_STAGES];

  always_comb begin
    logic [33:0] t;
    logic        ge;
    t  = 34'd0;
    ge = 1'b0;
    v_in[0] = in_valid;
    b_in[0] = in_beat;
    n_in[0] = in_norm;
    for (int j = 1; j < DIV_STAGES; j++) begin
      v_in[j] = v_r[j-1];
      b_in[j] = b_r[j-1];
      n_in[j] = n_r[j-1];
    end
    for (int l = 0; l < 3; l++) begin
      rem_in[l][0] = {2'b00, in_dvd[l][62:32]};
      low_in[l][0] = in_dvd[l][31:0];
      for (int j = 1; j < DIV_STAGES; j++) begin
        rem_in[l][j] = rem_r[l][j-1];
        low_in[l][j] = low_r[l][j-1];
      end
      for (int j = 0; j < DIV_STAGES; j++) begin
        t  = {rem_in[l][j], low_in[l][j][31]};
        ge = (t >= {1'b0, n_in[j]});
        rem_nxt[l][j] = ge ? 33'(t - {1'b0, n_in[j]}) : t[32:0];
        low_nxt[l][j] = {low_in[l][j][30:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_STAGES; j++) v_r[j] <= 1'b0;
    end else if (adv) begin
      for (int j = 0; j < DIV_STAGES; j++) v_r[j] <= v_in[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
        b_r[j] <= b_in[j];
        n_r[j] <= n_in[j];
        for (int l = 0; l < 3; l++) begin
          rem_r[l][j] <= rem_nxt[l][j];
          low_r[l][j] <= low_nxt[l][j];
        end
      end
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign out_beat  = b_r[DIV_STAGES-1];
  assign quot[0]   = low_r[0][DIV_STAGES-1];
  assign quot[1]   = low_r[1][DIV_STAGES-1];
  assign quot[2]   = low_r[2][DIV_STAGES-1];

endmodule

/* hdl/pose_to_rectangle_corners.sv */
// pose_to_rectangle_corners: top level; size registers, corner pipeline and
// output register. Uses p2rc_pkg, p2rc_terms, p2rc_corner, p2rc_div.
//
//   channel  dir  handshake                  beat
//   in_      in   in_valid / in_ready        one pose
//   out_     out  out_valid / out_ready      one corner, four per pose
//   cfg      in   psel/penable/pwrite/pready size registers at 0x0 and 0x4
//
// Pose rate is set by the four corner beats issued per pose; the next pose is
// taken while the last corner of the current one issues. A pose passes 3 term
// stages, 3 corner stages (hold, sign, bias), 32 divider stages (one quotient
// bit each) and 1 output register on its way to the corner port.
// Synchronous active-low reset empties the pipeline, sizes go to 1.0.
// A stalled output freezes every stage after the term stages; nothing drops.
`timescale 1ns / 1ps
module pose_to_rectangle_corners (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_position_x,
  input  logic signed [31:0]  in_position_y,
  input  logic signed [31:0]  in_position_z,
  input  logic signed [15:0]  in_quat_w,
  input  logic signed [15:0]  in_quat_x,
  input  logic signed [15:0]  in_quat_y,
  input  logic signed [15:0]  in_quat_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_corner_index,
  output logic signed [31:0]  out_corner_x,
  output logic signed [31:0]  out_corner_y,
  output logic signed [31:0]  out_corner_z,
  output logic                out_last_corner,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import p2rc_pkg::*;

  logic [30:0] width_r, height_r;
  logic adv;

  logic item_valid, item_ready;
  item_t item;

  logic cb_valid;
  beat_t cb;
  logic [32:0] cb_norm;
  logic [2:0][62:0] cb_dvd;

  logic dv_valid;
  beat_t db;
  logic [2:0][31:0] quot;

  logic signed [33:0] off [3];
  logic signed [33:0] sum [3];
  logic signed [31:0] pos [3];

  logic ov_r;
  logic [1:0] idx_r;
  logic signed [31:0] cx_r, cy_r, cz_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {1'b0, height_r} : {1'b0, width_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_WIDTH:  width_r  <= pwdata[30:0];
        REG_HEIGHT: height_r <= pwdata[30:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  assign adv = !ov_r || out_ready;

  p2rc_terms u_terms (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pos_x      (in_position_x),
    .pos_y      (in_position_y),
    .pos_z      (in_position_z),
    .qw         (in_quat_w),
    .qx         (in_quat_x),
    .qy         (in_quat_y),
    .qz         (in_quat_z),
    .half_w     (width_r[30:1]),
    .half_h     (height_r[30:1]),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  p2rc_corner u_corner (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .beat_valid (cb_valid),
    .beat       (cb),
    .norm       (cb_norm),
    .dvd        (cb_dvd)
  );

  p2rc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (cb_valid),
    .in_beat   (cb),
    .in_norm   (cb_norm),
    .in_dvd    (cb_dvd),
    .out_valid (dv_valid),
    .out_beat  (db),
    .quot      (quot)
  );

  always_comb begin
    pos[0] = db.pos_x;
    pos[1] = db.pos_y;
    pos[2] = db.pos_z;
    for (int i = 0; i < 3; i++) begin
      off[i] = db.neg[i] ? -$signed({2'b00, quot[i]}) : $signed({2'b00, quot[i]});
    end
    if (db.zero) begin
      off[0] = 34'(db.dx);
      off[1] = 34'(db.dy);
      off[2] = 34'sd0;
    end
    for (int i = 0; i < 3; i++) begin
      sum[i] = 34'(pos[i]) + off[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && dv_valid) begin
      idx_r <= db.idx;
      cx_r  <= sat32(sum[0]);
      cy_r  <= sat32(sum[1]);
      cz_r  <= sat32(sum[2]);
    end
  end

  assign out_valid        = ov_r;
  assign out_corner_index = idx_r;
  assign out_corner_x     = cx_r;
  assign out_corner_y     = cy_r;
  assign out_corner_z     = cz_r;
  assign out_last_corner  = (idx_r == CORNER_LAST);

endmodule

/* dv/pose_to_rectangle_corners_chk.sv */
// Corner checker: watches the pose and corner channels, predicts four corners
// per accepted pose, and compares them in order. Depends on the block's ports and p2rc_pkg only.
`timescale 1ns / 1ps
module pose_to_rectangle_corners_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_position_x,
  input  logic signed [31:0] in_position_y,
  input  logic signed [31:0] in_position_z,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_corner_index,
  input  logic signed [31:0] out_corner_x,
  input  logic signed [31:0] out_corner_y,
  input  logic signed [31:0] out_corner_z,
  input  logic               out_last_corner,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);
  import p2rc_pkg::*;

  typedef struct packed {
    logic [1:0]         idx;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic               last;
  } corner_t;

  corner_t     corner_q[$];
  logic [30:0] width_reg;
  logic [30:0] height_reg;

  function automatic longint round_div(longint s, longint n);
    longint m;
    longint q;
    m = (s < 0) ? -s : s;
    q = (m + (n >>> 1)) / n;
    return (s < 0) ? -q : q;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic predict_corners();
    longint pos[3];
    longint w, x, y, z, n, hw, hh, dx, dy, off;
    longint nm[3][2];
    corner_t c;
    pos[0] = in_position_x;
    pos[1] = in_position_y;
    pos[2] = in_position_z;
    w = in_quat_w;
    x = in_quat_x;
    y = in_quat_y;
    z = in_quat_z;
    hw = longint'(width_reg >> 1);
    hh = longint'(height_reg >> 1);
    n = w * w + x * x + y * y + z * z;
    nm[0][0] = w * w + x * x - y * y - z * z;
    nm[0][1] = 2 * (x * y - w * z);
    nm[1][0] = 2 * (x * y + w * z);
    nm[1][1] = w * w - x * x + y * y - z * z;
    nm[2][0] = 2 * (x * z - w * y);
    nm[2][1] = 2 * (y * z + w * x);
    for (int k = 0; k < 4; k++) begin
      dx = (k == 0 || k == 3) ? hw : -hw;
      dy = (k < 2) ? hh : -hh;
      c.idx = k[1:0];
      c.last = (k[1:0] == CORNER_LAST);
      for (int i = 0; i < 3; i++) begin
        if (n == 0) begin
          off = (i == 0) ? dx : ((i == 1) ? dy : 0);
        end else begin
          off = round_div(nm[i][0] * dx + nm[i][1] * dy, n);
        end
        case (i)
          0: c.cx = clamp32(pos[0] + off);
          1: c.cy = clamp32(pos[1] + off);
          default: c.cz = clamp32(pos[2] + off);
        endcase
      end
      corner_q = {corner_q, c};
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d want %0d", what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    corner_t e;
    if (!rst_n) begin
      width_reg <= SIZE_RESET;
      height_reg <= SIZE_RESET;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WIDTH) width_reg <= pwdata[30:0];
        else height_reg <= pwdata[30:0];
      end
      if (in_valid && in_ready) predict_corners();
      if (out_valid && out_ready) begin
        if (corner_q.size() == 0) begin
          report_mismatch("unexpected corner beat", out_corner_index, -1);
        end else begin
          e = corner_q.pop_front();
          if (out_corner_index != e.idx) report_mismatch("corner_index", out_corner_index, e.idx);
          if (out_corner_x != e.cx) report_mismatch("corner_x", out_corner_x, e.cx);
          if (out_corner_y != e.cy) report_mismatch("corner_y", out_corner_y, e.cy);
          if (out_corner_z != e.cz) report_mismatch("corner_z", out_corner_z, e.cz);
          if (out_last_corner != e.last)
            report_mismatch("last_corner", out_last_corner, e.last);
        end
      end
    end
    pending = corner_q.size();
  end
endmodule

/* dv/pose_to_rectangle_corners_tb.sv */
// Testbench top: drives poses, size-register writes and output stalls into
// pose_to_rectangle_corners; verdict comes from pose_to_rectangle_corners_chk.
`timescale 1ns / 1ps
module pose_to_rectangle_corners_tb;
  import p2rc_pkg::*;

  localparam int LATENCY = 39;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [2:0] ADDR_WIDTH = {REG_WIDTH, 2'b00};
  localparam logic [2:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_ready;
  logic signed [31:0] in_position_x = 0, in_position_y = 0, in_position_z = 0;
  logic signed [15:0] in_quat_w = 0, in_quat_x = 0, in_quat_y = 0, in_quat_z = 0;
  logic out_valid, out_ready = 0;
  logic [1:0] out_corner_index;
  logic signed [31:0] out_corner_x, out_corner_y, out_corner_z;
  logic out_last_corner;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;
  int fail_count, pending;
  bit quiet_tail = 0;
  bit hold_off = 0;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  pose_to_rectangle_corners u_top (.*);
  pose_to_rectangle_corners_chk u_chk (.*);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none in tail.
  initial begin
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end else if (!quiet_tail && $urandom_range(3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(13, 1)) @(negedge clk);
      end else begin
        out_ready <= 1;
        @(negedge clk);
      end
    end
  end

  task automatic write_size(logic [2:0] addr, logic [31:0] value);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= value; penable <= 0;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(negedge clk);
  endtask

  task automatic drain_corners();
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic send_pose(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [15:0] qw, logic [15:0] qx, logic [15:0] qy,
                           logic [15:0] qz);
    in_valid <= 1;
    in_position_x <= px; in_position_y <= py; in_position_z <= pz;
    in_quat_w <= qw; in_quat_x <= qx; in_quat_y <= qy; in_quat_z <= qz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (!quiet_tail && $urandom_range(3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(13, 1)) @(negedge clk);
    end
  endtask

  function automatic logic [15:0] rand_quat();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(32, 0)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(5))
      0: return 32'h7FFF_0000 + $urandom_range(32'hFFFF);
      1: return 32'h8000_0000 + $urandom_range(32'hFFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'(0);
      2: return 32'(1);
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: identity, zero quaternion, extremes, saturation, default sizes.
    send_pose(0, 0, 0, 16'h4000, 0, 0, 0);
    send_pose(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 0, 0, 0, 0);
    send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 16'h4000, 0, 0);
    send_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 16'h4000, 0);
    send_pose(0, 0, 0, 0, 0, 0, 16'h4000);
    send_pose(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_pose(0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_pose(5, -5, 7, 16'h0001, 0, 0, 16'h0001);
    send_pose(0, 0, 0, 16'h2D41, 0, 0, 16'h2D41);
    drain_corners();
    write_size(ADDR_WIDTH, 32'hFFFF_FFFF);
    write_size(ADDR_HEIGHT, 32'h7FFF_FFFF);
    send_pose(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0);
    send_pose(0, 0, 0, 16'h4000, 0, 0, 0);
    send_pose(0, 0, 32'h7FFF_0000, 16'h2D41, 16'h2D41, 0, 0);
    send_pose(0, 0, 0, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF);
    drain_corners();
    write_size(ADDR_WIDTH, 32'h0000_0003);
    write_size(ADDR_HEIGHT, 0);
    send_pose(1, 2, 3, 16'h4000, 0, 0, 0);
    send_pose(0, 0, 0, 16'h1234, 16'hE000, 16'h0777, 16'h8001);
    send_pose(0, 0, 0, 0, 0, 0, 0);
    drain_corners();
    write_size(ADDR_WIDTH, 0);
    write_size(ADDR_HEIGHT, 32'h0001_0001);
    send_pose(0, 0, 0, 16'h0ABC, 16'h1DEF, 16'hF123, 16'h0456);

    // Random phases with new sizes between them; fill the pipe once.
    for (int ph = 0; ph < 6; ph++) begin
      drain_corners();
      write_size(ADDR_WIDTH, rand_size());
      write_size(ADDR_HEIGHT, rand_size());
      if (ph == 1) hold_off = 1;
      if (ph == 5) quiet_tail = 1;
      for (int i = 0; i < 48; i++) begin
        if ($urandom_range(9) == 0)
          send_pose(rand_pos(), rand_pos(), rand_pos(), 0, 0, 0, 0);
        else
          send_pose(rand_pos(), rand_pos(), rand_pos(),
                    rand_quat(), rand_quat(), rand_quat(), rand_quat());
      end
    end
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
